>>> rtl/pddt_pkg.sv
// Shared types, constants and codes for the page dedup digest table.
// No dependencies; compile first.
package pddt_pkg;

   localparam int BUCKETS     = 4096;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int FRAME_BITS  = 40;
   localparam int WORD_BITS   = 64;
   localparam int WORDS       = 4;
   localparam int COUNT_BITS  = 32;
   localparam int KEEP_BITS   = 40;
   localparam int STEP_BITS   = 3;

   typedef enum logic [1:0] {
      KIND_OFFER  = 2'd0,
      KIND_FREE   = 2'd1,
      KIND_MERGE  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      VERDICT_STORED      = 3'd0,
      VERDICT_CANDIDATE   = 3'd1,
      VERDICT_SAME        = 3'd2,
      VERDICT_COLLISION   = 3'd3,
      VERDICT_INVALIDATED = 3'd4,
      VERDICT_NOT_FOUND   = 3'd5,
      VERDICT_MERGED      = 3'd6
   } verdict_type;

   typedef logic [WORDS-1:0][WORD_BITS-1:0] digest_type;

   typedef struct packed {
      logic                  valid;
      logic [FRAME_BITS-1:0] frame;
      digest_type            digest;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

>>> rtl/pddt_ifs.sv
// Request and response channel interfaces of the page dedup digest table.
// Depends on pddt_pkg.
interface pddt_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [39:0]                     page_frame;
   logic [pddt_pkg::WORD_BITS-1:0]  digest_word0;
   logic [pddt_pkg::WORD_BITS-1:0]  digest_word1;
   logic [pddt_pkg::WORD_BITS-1:0]  digest_word2;
   logic [pddt_pkg::WORD_BITS-1:0]  digest_word3;

   modport source (output valid, kind, page_frame, digest_word0, digest_word1,
                   digest_word2, digest_word3, input ready);
   modport sink   (input valid, kind, page_frame, digest_word0, digest_word1,
                   digest_word2, digest_word3, output ready);
endinterface

interface pddt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [2:0]                       verdict;
   logic [pddt_pkg::KEEP_BITS-1:0]   keep_frame;
   logic [pddt_pkg::COUNT_BITS-1:0]  scanned_count;
   logic [pddt_pkg::COUNT_BITS-1:0]  shared_count;
   logic [pddt_pkg::COUNT_BITS-1:0]  merged_count;

   modport source (output valid, verdict, keep_frame, scanned_count, shared_count,
                   merged_count, input ready);
   modport sink   (input valid, verdict, keep_frame, scanned_count, shared_count,
                   merged_count, output ready);
endinterface

>>> rtl/pddt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pddt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/page_dedup_digest_table.sv
// Top level of the page dedup digest table: sequencer, counters, output register.
// Depends on pddt_pkg, pddt_ifs (channel interfaces) and pddt_ram (entry store).
//
//  channel   | direction | transfer carries
//  ----------+-----------+--------------------------------------------------------------
//  req_chan  | in        | kind, page_frame, digest_word0..digest_word3
//  rsp_chan  | out       | verdict, keep_frame, scanned_count, shared_count, merged_count
//
// Steps: a merge goes straight to the done state; an offer does one RAM read, then one
// 64-bit compare per step over the four digest words and the frame; a free has one entry
// read and compared per cycle from bucket 0 upward.
// Reset: synchronous; then a clearing pass over all BUCKETS (4096) entries writes each
// one invalid, and req_chan.ready stays low until it ends.
// Stalls: a held result does not block the next transfer in; the next result waits in
// the done state until the output register is free. Drop an unused kind silently.
module page_dedup_digest_table (
   input  logic              clock,
   input  logic              reset,
   pddt_req_if.sink          req_chan,
   pddt_rsp_if.source        rsp_chan
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFER,
      ST_FREE,
      ST_DONE
   } state_type;

   localparam logic [pddt_pkg::BUCKET_BITS-1:0] LAST_BUCKET =
      pddt_pkg::BUCKET_BITS'(pddt_pkg::BUCKETS - 1);
   localparam logic [pddt_pkg::STEP_BITS-1:0] FRAME_STEP =
      pddt_pkg::STEP_BITS'(pddt_pkg::WORDS);

   state_type                             state_ff, state_in;
   logic [pddt_pkg::BUCKET_BITS-1:0]      idx_ff, idx_in;
   logic [pddt_pkg::STEP_BITS-1:0]        step_ff, step_in;
   logic [pddt_pkg::FRAME_BITS-1:0]       item_frame_ff, item_frame_in;
   pddt_pkg::digest_type                  item_digest_ff, item_digest_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       scanned_ff, scanned_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       shared_ff, shared_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       merged_ff, merged_in;
   pddt_pkg::verdict_type                 verdict_ff, verdict_in;
   logic [pddt_pkg::KEEP_BITS-1:0]        keep_ff, keep_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   pddt_pkg::verdict_type                 rsp_verdict_ff, rsp_verdict_in;
   logic [pddt_pkg::KEEP_BITS-1:0]        rsp_keep_ff, rsp_keep_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       rsp_scanned_ff, rsp_scanned_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       rsp_shared_ff, rsp_shared_in;
   logic [pddt_pkg::COUNT_BITS-1:0]       rsp_merged_ff, rsp_merged_in;

   // entry store ports
   logic                                  ram_wr_en;
   logic [pddt_pkg::BUCKET_BITS-1:0]      ram_wr_addr;
   pddt_pkg::entry_type                   ram_wr_data;
   logic                                  ram_rd_en;
   logic [pddt_pkg::BUCKET_BITS-1:0]      ram_rd_addr;
   logic [pddt_pkg::ENTRY_BITS-1:0]       ram_rd_bits;
   pddt_pkg::entry_type                   rd_entry;

   // shared 64-bit equality unit
   logic [pddt_pkg::WORD_BITS-1:0]        cmp_a;
   logic [pddt_pkg::WORD_BITS-1:0]        cmp_b;
   logic                                  cmp_eq;

   pddt_ram #(
      .WIDTH (pddt_pkg::ENTRY_BITS),
      .DEPTH (pddt_pkg::BUCKETS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign rd_entry = pddt_pkg::entry_type'(ram_rd_bits);

   // Select the operands: a digest word per offer step, the frame on the last
   // offer step and on every step of a free scan.
   always_comb begin
      if (state_ff == ST_FREE || step_ff == FRAME_STEP) begin
         cmp_a = pddt_pkg::WORD_BITS'(rd_entry.frame);
         cmp_b = pddt_pkg::WORD_BITS'(item_frame_ff);
      end else begin
         cmp_a = rd_entry.digest[step_ff[1:0]];
         cmp_b = item_digest_ff[step_ff[1:0]];
      end
   end

   assign cmp_eq = (cmp_a == cmp_b);

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      step_in        = step_ff;
      item_frame_in  = item_frame_ff;
      item_digest_in = item_digest_ff;
      scanned_in     = scanned_ff;
      shared_in      = shared_ff;
      merged_in      = merged_ff;
      verdict_in     = verdict_ff;
      keep_in        = keep_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_keep_in    = rsp_keep_ff;
      rsp_scanned_in = rsp_scanned_ff;
      rsp_shared_in  = rsp_shared_ff;
      rsp_merged_in  = rsp_merged_ff;
      // drop the held result once its transfer completes
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the store, one invalid entry a cycle
            ram_wr_en = 1'b1;
            if (idx_ff == LAST_BUCKET) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_chan.valid) begin
               item_frame_in     = req_chan.page_frame[pddt_pkg::FRAME_BITS-1:0];
               item_digest_in[0] = req_chan.digest_word0;
               item_digest_in[1] = req_chan.digest_word1;
               item_digest_in[2] = req_chan.digest_word2;
               item_digest_in[3] = req_chan.digest_word3;
               keep_in           = '0;
               unique case (pddt_pkg::kind_type'(req_chan.kind))
                  pddt_pkg::KIND_OFFER: begin
                     // bucket is the low digest bits; fetch its entry
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = req_chan.digest_word0[pddt_pkg::BUCKET_BITS-1:0];
                     idx_in      = req_chan.digest_word0[pddt_pkg::BUCKET_BITS-1:0];
                     step_in     = '0;
                     scanned_in  = scanned_ff + 1'b1;
                     state_in    = ST_OFFER;
                  end
                  pddt_pkg::KIND_FREE: begin
                     // start the scan at bucket 0
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     state_in    = ST_FREE;
                  end
                  pddt_pkg::KIND_MERGE: begin
                     merged_in  = merged_ff + 1'b1;
                     shared_in  = shared_ff + 1'b1;
                     verdict_in = pddt_pkg::VERDICT_MERGED;
                     state_in   = ST_DONE;
                  end
                  default: begin
                     // unused kind: take the transfer, give no result
                  end
               endcase
            end
         end

         ST_OFFER: begin
            if (!rd_entry.valid) begin
               // empty bucket: store the digest and frame
               ram_wr_en         = 1'b1;
               ram_wr_data.valid = 1'b1;
               ram_wr_data.frame = item_frame_ff;
               ram_wr_data.digest = item_digest_ff;
               verdict_in        = pddt_pkg::VERDICT_STORED;
               state_in          = ST_DONE;
            end else if (!cmp_eq) begin
               if (step_ff == FRAME_STEP) begin
                  verdict_in = pddt_pkg::VERDICT_CANDIDATE;
                  keep_in    = pddt_pkg::KEEP_BITS'(rd_entry.frame);
               end else begin
                  verdict_in = pddt_pkg::VERDICT_COLLISION;
               end
               state_in = ST_DONE;
            end else if (step_ff == FRAME_STEP) begin
               verdict_in = pddt_pkg::VERDICT_SAME;
               state_in   = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_FREE: begin
            if (rd_entry.valid && cmp_eq) begin
               // first holder of the frame: invalidate it in place
               ram_wr_en         = 1'b1;
               ram_wr_data       = rd_entry;
               ram_wr_data.valid = 1'b0;
               if (shared_ff != '0) begin
                  shared_in = shared_ff - 1'b1;
               end
               verdict_in = pddt_pkg::VERDICT_INVALIDATED;
               state_in   = ST_DONE;
            end else if (idx_ff == LAST_BUCKET) begin
               verdict_in = pddt_pkg::VERDICT_NOT_FOUND;
               state_in   = ST_DONE;
            end else begin
               // advance: fetch the next entry while this one is compared
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + 1'b1;
               idx_in      = idx_ff + 1'b1;
            end
         end

         ST_DONE: begin
            // hold until the output register is free, then load it
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = verdict_ff;
               rsp_keep_in    = keep_ff;
               rsp_scanned_in = scanned_ff;
               rsp_shared_in  = shared_ff;
               rsp_merged_in  = merged_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         step_ff      <= '0;
         scanned_ff   <= '0;
         shared_ff    <= '0;
         merged_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         scanned_ff   <= scanned_in;
         shared_ff    <= shared_in;
         merged_ff    <= merged_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_frame_ff  <= item_frame_in;
      item_digest_ff <= item_digest_in;
      verdict_ff     <= verdict_in;
      keep_ff        <= keep_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_keep_ff    <= rsp_keep_in;
      rsp_scanned_ff <= rsp_scanned_in;
      rsp_shared_ff  <= rsp_shared_in;
      rsp_merged_ff  <= rsp_merged_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.verdict       = rsp_verdict_ff;
   assign rsp_chan.keep_frame    = rsp_keep_ff;
   assign rsp_chan.scanned_count = rsp_scanned_ff;
   assign rsp_chan.shared_count  = rsp_shared_ff;
   assign rsp_chan.merged_count  = rsp_merged_ff;

endmodule

>>> rtl/pddt_checker.sv
// Port-level checker for the page dedup digest table, bound to the top level.
// Depends on pddt_pkg and page_dedup_digest_table.
module pddt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [1:0]                       req_kind,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [2:0]                       rsp_verdict,
   input logic [pddt_pkg::KEEP_BITS-1:0]   rsp_keep_frame,
   input logic [pddt_pkg::COUNT_BITS-1:0]  rsp_shared_count
);

   // no request taken in the first cycle after reset: the clearing pass runs
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request channel ready during clearing pass");

   // a request that yields a result keeps the sequencer busy in the cycle after it is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind != 2'(pddt_pkg::KIND_UNUSED)) |=> !req_ready)
      else $error("request channel ready straight after a transfer");

   // keep_frame is only meaningful for a candidate
   a_keep_only_candidate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_verdict != 3'(pddt_pkg::VERDICT_CANDIDATE))
         |-> (rsp_keep_frame == '0))
      else $error("keep_frame set on a non-candidate result");

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its verdict, keep_frame and shared_count
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_verdict) && $stable(rsp_keep_frame) && $stable(rsp_shared_count)))
      else $error("result payload changed while stalled");

endmodule

bind page_dedup_digest_table pddt_checker u_pddt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_kind         (req_chan.kind),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_verdict      (rsp_chan.verdict),
   .rsp_keep_frame   (rsp_chan.keep_frame),
   .rsp_shared_count (rsp_chan.shared_count)
);

>>> test/page_dedup_digest_table_tb.sv
// Self-checking testbench for the page dedup digest table: directed and random
// offer, free, merge and unused-kind transfers, each result compared against a local predictor.
// Depends on pddt_pkg, pddt_ifs and the page_dedup_digest_table RTL.
module page_dedup_digest_table_tb;

   localparam int RANDOM_ITEMS   = 900;
   localparam int IDLE_LIMIT     = 20000;  // clearing pass or a full free scan, plus stalls
   localparam int DRAIN_CYCLES   = 64;
   localparam int POOL_DEPTH     = 48;
   localparam int MISMATCH_PRINT = 200;

   typedef struct {
      pddt_pkg::kind_type    kind;
      logic [39:0]           frame;
      pddt_pkg::digest_type  digest;
   } page_request_type;

   typedef struct {
      pddt_pkg::verdict_type               verdict;
      logic [pddt_pkg::KEEP_BITS-1:0]      keep;
      logic [pddt_pkg::COUNT_BITS-1:0]     scanned;
      logic [pddt_pkg::COUNT_BITS-1:0]     shared;
      logic [pddt_pkg::COUNT_BITS-1:0]     merged;
   } digest_verdict_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_PULSE,
      SINK_CHOKE
   } sink_mode_type;

   logic clock;
   logic reset;

   pddt_req_if req_if ();
   pddt_rsp_if rsp_if ();

   page_dedup_digest_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Pending requests for the driver, and verdicts still owed by the block.
   page_request_type   pending_requests [$];
   digest_verdict_type expected_verdicts [$];
   page_request_type   offered_pool [$];

   // Local copy of the table and its counters.
   bit                                slot_live   [pddt_pkg::BUCKETS];
   logic [pddt_pkg::FRAME_BITS-1:0]   slot_frame  [pddt_pkg::BUCKETS];
   pddt_pkg::digest_type              slot_digest [pddt_pkg::BUCKETS];
   logic [pddt_pkg::COUNT_BITS-1:0]   offers_seen  = '0;
   logic [pddt_pkg::COUNT_BITS-1:0]   shared_pages = '0;
   logic [pddt_pkg::COUNT_BITS-1:0]   merges_done  = '0;

   int mismatch_count = 0;
   int result_index   = 0;
   int idle_cycles    = 0;
   int burst_left     = 1;
   int gap_left       = 0;
   int mode_left      = 0;
   int sink_phase     = 0;
   sink_mode_type sink_mode = SINK_OPEN;

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [39:0] rand_frame();
      return 40'(rand_word());
   endfunction

   function automatic pddt_pkg::digest_type make_digest(
      input logic [63:0] w0, input logic [63:0] w1,
      input logic [63:0] w2, input logic [63:0] w3);
      return {w3, w2, w1, w0};
   endfunction

   // Random digest; unless spread, fold the bucket into the low 256 so that
   // hits, collisions and short free scans stay common.
   function automatic pddt_pkg::digest_type fresh_digest(input bit spread);
      pddt_pkg::digest_type d;
      d = make_digest(rand_word(), rand_word(), rand_word(), rand_word());
      if (!spread)
         d[0] = (d[0] & ~64'(pddt_pkg::BUCKETS - 1)) | 64'($urandom_range(255, 0));
      return d;
   endfunction

   task automatic queue_request(input pddt_pkg::kind_type k, input logic [39:0] f,
                                input pddt_pkg::digest_type d);
      page_request_type r;
      r.kind   = k;
      r.frame  = f;
      r.digest = d;
      pending_requests.push_back(r);
   endtask

   // Work out the verdict of one accepted request and advance the local table.
   task automatic predict_verdict(input page_request_type req);
      digest_verdict_type                r;
      logic [pddt_pkg::FRAME_BITS-1:0]   fr;
      logic [pddt_pkg::BUCKET_BITS-1:0]  b;
      bit                                hit;
      fr     = req.frame[pddt_pkg::FRAME_BITS-1:0];
      r.keep = '0;
      case (req.kind)
         pddt_pkg::KIND_OFFER: begin
            b = req.digest[0][pddt_pkg::BUCKET_BITS-1:0];
            offers_seen++;
            if (!slot_live[b]) begin
               slot_live[b]   = 1'b1;
               slot_frame[b]  = fr;
               slot_digest[b] = req.digest;
               r.verdict      = pddt_pkg::VERDICT_STORED;
            end else if (slot_digest[b] == req.digest) begin
               if (slot_frame[b] != fr) begin
                  r.verdict = pddt_pkg::VERDICT_CANDIDATE;
                  r.keep    = pddt_pkg::KEEP_BITS'(slot_frame[b]);
               end else begin
                  r.verdict = pddt_pkg::VERDICT_SAME;
               end
            end else begin
               r.verdict = pddt_pkg::VERDICT_COLLISION;
            end
         end
         pddt_pkg::KIND_FREE: begin
            // First live entry holding the frame, from bucket 0 upward.
            hit = 1'b0;
            for (int i = 0; i < pddt_pkg::BUCKETS && !hit; i++) begin
               if (slot_live[i] && slot_frame[i] == fr) begin
                  slot_live[i] = 1'b0;
                  hit          = 1'b1;
               end
            end
            if (hit) begin
               if (shared_pages != '0)
                  shared_pages--;
               r.verdict = pddt_pkg::VERDICT_INVALIDATED;
            end else begin
               r.verdict = pddt_pkg::VERDICT_NOT_FOUND;
            end
         end
         pddt_pkg::KIND_MERGE: begin
            merges_done++;
            shared_pages++;
            r.verdict = pddt_pkg::VERDICT_MERGED;
         end
         default: return;  // unused kind: dropped, no result
      endcase
      r.scanned = offers_seen;
      r.shared  = shared_pages;
      r.merged  = merges_done;
      expected_verdicts.push_back(r);
   endtask

   task automatic report_mismatch(input string note);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_PRINT)
         $display("mismatch on result %0d: %s", result_index, note);
   endtask

   task automatic check_result();
      digest_verdict_type want;
      if (expected_verdicts.size() == 0) begin
         report_mismatch($sformatf("result with nothing outstanding, verdict %0d",
                                   rsp_if.verdict));
         result_index++;
         return;
      end
      want = expected_verdicts.pop_front();
      if (rsp_if.verdict !== want.verdict)
         report_mismatch($sformatf("verdict %0d, want %0d", rsp_if.verdict, want.verdict));
      if (rsp_if.keep_frame !== want.keep)
         report_mismatch($sformatf("keep_frame %h, want %h", rsp_if.keep_frame, want.keep));
      if (rsp_if.scanned_count !== want.scanned)
         report_mismatch($sformatf("scanned_count %0d, want %0d",
                                   rsp_if.scanned_count, want.scanned));
      if (rsp_if.shared_count !== want.shared)
         report_mismatch($sformatf("shared_count %0d, want %0d",
                                   rsp_if.shared_count, want.shared));
      if (rsp_if.merged_count !== want.merged)
         report_mismatch($sformatf("merged_count %0d, want %0d",
                                   rsp_if.merged_count, want.merged));
      result_index++;
   endtask

   // Driver: present the head of the pending queue, hold it until the transfer,
   // then predict it. Bursts of random length, random gaps between them.
   always @(posedge clock) begin : request_driver
      page_request_type item;
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.kind         <= pddt_pkg::KIND_OFFER;
         req_if.page_frame   <= '0;
         req_if.digest_word0 <= '0;
         req_if.digest_word1 <= '0;
         req_if.digest_word2 <= '0;
         req_if.digest_word3 <= '0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_if.valid) begin
            item = pending_requests.pop_front();
            predict_verdict(item);
            burst_left--;
            if (burst_left <= 0) begin
               // Mostly short bursts; now and then a long run with no gap at all.
               if ($urandom_range(3, 0) == 0) begin
                  burst_left = $urandom_range(60, 20);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(8, 1);
                  gap_left   = $urandom_range(40, 0);
               end
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            item = pending_requests[0];
            req_if.valid        <= 1'b1;
            req_if.kind         <= item.kind;
            req_if.page_frame   <= item.frame;
            req_if.digest_word0 <= item.digest[0];
            req_if.digest_word1 <= item.digest[1];
            req_if.digest_word2 <= item.digest[2];
            req_if.digest_word3 <= item.digest[3];
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each result transfer; drive ready from a shifting stall pattern.
   always @(posedge clock) begin : result_monitor
      logic next_ready;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_result();
         if (mode_left == 0) begin
            sink_mode = sink_mode_type'($urandom_range(3, 0));
            mode_left = $urandom_range(300, 20);
         end
         mode_left--;
         sink_phase++;
         case (sink_mode)
            SINK_OPEN:  next_ready = 1'b1;
            SINK_COIN:  next_ready = 1'($urandom_range(1, 0));
            SINK_PULSE: next_ready = (sink_phase % 4) == 0;
            default:    next_ready = (sink_phase % 24) >= 18;  // long stalls
         endcase
         rsp_if.ready <= next_ready;
      end
   end

   // Watchdog: end the run if no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      pddt_pkg::digest_type dig_a, dig_b, dig_c, dig_d, alt;
      page_request_type     chosen;
      logic [39:0]          fr, f1, f2;
      logic [63:0]          flip;
      int                   pick, idx, word_sel, real_items;

      reset = 1'b1;

      // Directed part.
      dig_a = make_digest(64'h0123_4567_89AB_C005, 64'hFEDC_BA98_7654_3210,
                          64'h5555_AAAA_5555_AAAA, 64'h8000_0000_0000_0001);
      dig_b = make_digest('1, '1, '1, '1);            // top bucket
      dig_c = make_digest('0, '0, '0, '0);            // bucket 0
      dig_d = make_digest(64'h7777_0000_1234_5007, 64'h1, 64'h2, 64'h3);
      f1    = 40'hA5_5A5A_5A5A;
      f2    = 40'h00_0000_0001;

      queue_request(pddt_pkg::KIND_FREE,  f1, dig_c);  // free on an empty table
      queue_request(pddt_pkg::KIND_OFFER, f1, dig_a);  // empty bucket: store
      queue_request(pddt_pkg::KIND_OFFER, f1, dig_a);  // same digest, same frame
      queue_request(pddt_pkg::KIND_OFFER, f2, dig_a);  // same digest, new frame: candidate
      queue_request(pddt_pkg::KIND_MERGE, '1, dig_b);  // merge ignores its payload
      // Differ in one digest word at a time; word 0 only above the bucket bits.
      alt = dig_a; alt[0] ^= 64'h8000_0000_0000_0000;
      queue_request(pddt_pkg::KIND_OFFER, f2, alt);
      alt = dig_a; alt[1] ^= 64'h1;
      queue_request(pddt_pkg::KIND_OFFER, f2, alt);
      alt = dig_a; alt[2] ^= 64'h8000_0000_0000_0000;
      queue_request(pddt_pkg::KIND_OFFER, f1, alt);
      alt = dig_a; alt[3] ^= '1;
      queue_request(pddt_pkg::KIND_OFFER, f2, alt);
      queue_request(pddt_pkg::KIND_OFFER, '1, dig_b);
      queue_request(pddt_pkg::KIND_OFFER, '0, dig_c);
      queue_request(pddt_pkg::KIND_OFFER, f1, dig_d);  // f1 now held in two buckets
      queue_request(pddt_pkg::KIND_FREE,  f1, dig_c);  // lower bucket goes first
      queue_request(pddt_pkg::KIND_FREE,  f1, dig_c);  // shared count saturates at zero
      queue_request(pddt_pkg::KIND_FREE,  f1, dig_c);  // gone: not found
      queue_request(pddt_pkg::KIND_OFFER, f2, dig_a);  // freed bucket refills
      queue_request(pddt_pkg::KIND_UNUSED, '1, dig_b); // dropped, no result
      queue_request(pddt_pkg::KIND_FREE,  '1, dig_c);  // scan to the last bucket
      queue_request(pddt_pkg::KIND_FREE,  '0, dig_b);
      queue_request(pddt_pkg::KIND_MERGE, '0, dig_c);
      queue_request(pddt_pkg::KIND_MERGE, f2, dig_a);
      queue_request(pddt_pkg::KIND_OFFER, f1, dig_a);  // candidate keeps f2

      // Random part: mostly well-formed traffic around a pool of offered pages.
      real_items = 0;
      while (real_items < RANDOM_ITEMS) begin
         pick = $urandom_range(99, 0);
         if (offered_pool.size() == 0 &&
             (pick < 30 || (pick >= 52 && pick < 60) || (pick >= 75 && pick < 88)))
            pick = 30;
         if (pick < 30) begin
            // Re-offer a known digest: same frame, a fresh one, or another page's.
            chosen = offered_pool[$urandom_range(offered_pool.size() - 1, 0)];
            case ($urandom_range(2, 0))
               0:       fr = chosen.frame;
               1:       fr = rand_frame();
               default: fr = offered_pool[$urandom_range(offered_pool.size() - 1, 0)].frame;
            endcase
            queue_request(pddt_pkg::KIND_OFFER, fr, chosen.digest);
         end else if (pick < 52) begin
            alt = fresh_digest($urandom_range(3, 0) == 0);
            if (offered_pool.size() > 0 && $urandom_range(4, 0) == 0)
               fr = offered_pool[$urandom_range(offered_pool.size() - 1, 0)].frame;
            else
               fr = rand_frame();
            queue_request(pddt_pkg::KIND_OFFER, fr, alt);
            chosen.kind   = pddt_pkg::KIND_OFFER;
            chosen.frame  = fr;
            chosen.digest = alt;
            offered_pool.push_back(chosen);
            if (offered_pool.size() > POOL_DEPTH)
               void'(offered_pool.pop_front());
         end else if (pick < 60) begin
            // Near miss: flip bits in one word, keeping the bucket.
            chosen   = offered_pool[$urandom_range(offered_pool.size() - 1, 0)];
            word_sel = $urandom_range(pddt_pkg::WORDS - 1, 0);
            flip     = rand_word();
            if (word_sel == 0) begin
               flip = flip & ~64'(pddt_pkg::BUCKETS - 1);
               flip[$urandom_range(63, pddt_pkg::BUCKET_BITS)] = 1'b1;
            end else begin
               flip[$urandom_range(63, 0)] = 1'b1;
            end
            alt = chosen.digest;
            alt[word_sel] ^= flip;
            queue_request(pddt_pkg::KIND_OFFER,
                          $urandom_range(1, 0) ? chosen.frame : rand_frame(), alt);
         end else if (pick < 75) begin
            queue_request(pddt_pkg::KIND_MERGE, rand_frame(), fresh_digest(1'b1));
         end else if (pick < 88) begin
            // Free a pooled page; drop it from the pool so re-frees stay rare.
            idx = $urandom_range(offered_pool.size() - 1, 0);
            queue_request(pddt_pkg::KIND_FREE, offered_pool[idx].frame, fresh_digest(1'b1));
            offered_pool.delete(idx);
         end else if (pick < 92) begin
            queue_request(pddt_pkg::KIND_FREE, rand_frame(), fresh_digest(1'b1));
         end else if (pick < 95) begin
            queue_request(pddt_pkg::KIND_UNUSED, rand_frame(), fresh_digest(1'b1));
            real_items--;  // dropped items do not count
         end else begin
            queue_request(pddt_pkg::KIND_OFFER, rand_frame(), fresh_digest(1'b1));
         end
         real_items++;
      end

      // Release reset.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to go across, then for every verdict.
      do @(posedge clock); while (pending_requests.size() != 0 || req_if.valid);
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_verdicts.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> page_dedup_digest_table.f
rtl/pddt_pkg.sv
rtl/pddt_ifs.sv
rtl/pddt_ram.sv
rtl/page_dedup_digest_table.sv
rtl/pddt_checker.sv
test/page_dedup_digest_table_tb.sv
